// ----- hw/rtl/sst_pkg.sv -----
// shared types, constants and key conversion helpers for the sorted set table
package sst_pkg;

    localparam int CAPACITY  = 32;
    localparam int KEY_WIDTH = 32;
    localparam int PORT_W    = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic signed [PORT_W-1:0]    port_key_t;
    typedef logic [CAPACITY-1:0]         row_t;
    typedef logic [CNT_W-1:0]            count_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_DUMP   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_BELOW   = 3'd3,
        ST_ABOVE   = 3'd4,
        ST_BETWEEN = 3'd5,
        ST_FULL    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_CMP    = 3'd1,
        S_DECIDE = 3'd2,
        S_PREV   = 3'd3,
        S_QEMIT  = 3'd4,
        S_DUMP   = 3'd5
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic compare;
        logic commit;
        logic load_prev;
        logic emit_result;
        logic emit_query;
        logic emit_dump;
        logic dump_start;
        logic dump_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic is_dump;
        logic dec_ok;
        logic cnt_zero;
        logic dump_last;
    } dp_stat_t;

    // cut or sign-extend a port key to the stored key width
    function automatic key_t key_from_port(input port_key_t p);
        return KEY_WIDTH'(p);
    endfunction

    // stored key back to port width
    function automatic port_key_t key_to_port(input key_t k);
        return PORT_W'(k);
    endfunction

endpackage

// ----- hw/rtl/sst_ctrl.sv -----
// control state machine of the sorted set table
module sst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  sst_pkg::dp_stat_t stat,
    output sst_pkg::cmd_t     cmd
);

    sst_pkg::state_t state_reg;
    sst_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;
    logic            emit;

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = cmd.emit_result || cmd.emit_query || cmd.emit_dump;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sst_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = sst_pkg::S_CMP;
            end
            sst_pkg::S_CMP:
                state_next = sst_pkg::S_DECIDE;
            sst_pkg::S_DECIDE:
            begin
                if (stat.is_dump && !stat.cnt_zero)
                    state_next = sst_pkg::S_DUMP;
                else if (stat.is_query && stat.dec_ok)
                    state_next = sst_pkg::S_PREV;
                else if (out_free)
                    state_next = sst_pkg::S_IDLE;
            end
            sst_pkg::S_PREV:
                state_next = sst_pkg::S_QEMIT;
            sst_pkg::S_QEMIT:
            begin
                if (out_free)
                    state_next = sst_pkg::S_IDLE;
            end
            sst_pkg::S_DUMP:
            begin
                if (out_free && stat.dump_last)
                    state_next = sst_pkg::S_IDLE;
            end
            default:
                state_next = sst_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            sst_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            sst_pkg::S_CMP:
                cmd.compare = 1'b1;
            sst_pkg::S_DECIDE:
            begin
                if (stat.is_dump && !stat.cnt_zero)
                    cmd.dump_start = 1'b1;
                else if (!(stat.is_query && stat.dec_ok) && out_free)
                begin
                    cmd.emit_result = 1'b1;
                    cmd.commit      = stat.dec_ok;
                end
            end
            sst_pkg::S_PREV:
                cmd.load_prev = 1'b1;
            sst_pkg::S_QEMIT:
                cmd.emit_query = out_free;
            sst_pkg::S_DUMP:
            begin
                cmd.emit_dump = out_free;
                cmd.dump_step = out_free;
            end
            default:
                in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sst_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result is never loaded over one that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_valid_reg) |-> !out_stall)
        else $error("result loaded over a stalled result");

endmodule

// ----- hw/rtl/sst_dp.sv -----
// key table, compare row, neighbor select and result register
module sst_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sst_pkg::cmd_t               cmd,
    output sst_pkg::dp_stat_t           stat,
    input  logic [1:0]                  action,
    input  logic signed [31:0]          key,
    output logic [2:0]                  status,
    output logic signed [31:0]          value,
    output logic                        has_next,
    output logic signed [31:0]          next_value,
    output logic                        has_prev,
    output logic signed [31:0]          prev_value,
    output logic                        last
);

    localparam int CAP = sst_pkg::CAPACITY;

    sst_pkg::key_t    keys_reg  [CAP];
    sst_pkg::key_t    keys_next [CAP];
    sst_pkg::count_t  count_reg;
    sst_pkg::count_t  count_next;
    sst_pkg::key_t    key_reg;
    sst_pkg::action_t action_reg;
    sst_pkg::row_t    lt_reg;
    sst_pkg::row_t    eq_reg;
    sst_pkg::row_t    dump_oh_reg;
    sst_pkg::key_t    prev_reg;

    sst_pkg::row_t    vld;
    sst_pkg::row_t    lt_next;
    sst_pkg::row_t    eq_next;
    sst_pkg::row_t    ins_pos;
    sst_pkg::row_t    prev_oh;
    sst_pkg::row_t    next_oh;
    sst_pkg::row_t    sel_oh;
    sst_pkg::key_t    sel_key;
    sst_pkg::status_t dec;
    sst_pkg::status_t miss;
    logic             found;
    logic             full;
    logic             cnt_zero;

    logic [2:0]          status_reg;
    logic signed [31:0]  value_reg;
    logic                has_next_reg;
    logic signed [31:0]  next_value_reg;
    logic                has_prev_reg;
    logic signed [31:0]  prev_value_reg;
    logic                last_reg;

    // occupancy row and per-cell compare
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            vld[i]     = sst_pkg::CNT_W'(i) < count_reg;
            lt_next[i] = vld[i] && (keys_reg[i] < key_reg);
            eq_next[i] = vld[i] && (keys_reg[i] == key_reg);
        end
    end

    // insert point, neighbor rows
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            if (i == 0)
                ins_pos[i] = !lt_reg[i];
            else
                ins_pos[i] = !lt_reg[i] && lt_reg[i-1];
            if (i == CAP - 1)
                prev_oh[i] = lt_reg[i];
            else
                prev_oh[i] = lt_reg[i] && !lt_reg[i+1];
            if (i == 0)
                next_oh[i] = 1'b0;
            else
                next_oh[i] = eq_reg[i-1] && vld[i];
        end
    end

    // one shared and-or select over the row
    always_comb
    begin
        if (cmd.load_prev)
            sel_oh = prev_oh;
        else if (cmd.emit_query)
            sel_oh = next_oh;
        else
            sel_oh = dump_oh_reg;
        sel_key = '0;
        for (int i = 0; i < CAP; i++)
            sel_key = sel_key | (keys_reg[i] & {sst_pkg::KEY_WIDTH{sel_oh[i]}});
    end

    // decision
    always_comb
    begin
        found    = |eq_reg;
        cnt_zero = count_reg == '0;
        full     = count_reg == sst_pkg::CNT_W'(CAP);
        if (!lt_reg[0])
            miss = sst_pkg::ST_BELOW;
        else if (lt_reg == vld)
            miss = sst_pkg::ST_ABOVE;
        else
            miss = sst_pkg::ST_BETWEEN;
        case (action_reg)
            sst_pkg::ACT_INSERT:
            begin
                if (found)
                    dec = sst_pkg::ST_DUP;
                else if (full)
                    dec = sst_pkg::ST_FULL;
                else
                    dec = sst_pkg::ST_OK;
            end
            sst_pkg::ACT_DELETE, sst_pkg::ACT_QUERY:
            begin
                if (cnt_zero)
                    dec = sst_pkg::ST_EMPTY;
                else if (found)
                    dec = sst_pkg::ST_OK;
                else
                    dec = miss;
            end
            default:
                dec = sst_pkg::ST_EMPTY;
        endcase
    end

    assign stat.is_query  = action_reg == sst_pkg::ACT_QUERY;
    assign stat.is_dump   = action_reg == sst_pkg::ACT_DUMP;
    assign stat.dec_ok    = dec == sst_pkg::ST_OK;
    assign stat.cnt_zero  = cnt_zero;
    assign stat.dump_last = ((dump_oh_reg << 1) & vld) == '0;

    // table update: shift up on insert, shift down on delete
    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < CAP; i++)
            keys_next[i] = keys_reg[i];
        if (cmd.commit && action_reg == sst_pkg::ACT_INSERT)
        begin
            count_next = count_reg + sst_pkg::CNT_W'(1);
            for (int i = 0; i < CAP; i++)
            begin
                if (ins_pos[i])
                    keys_next[i] = key_reg;
                else if (!lt_reg[i] && i > 0)
                    keys_next[i] = keys_reg[(i > 0) ? i - 1 : 0];
            end
        end
        else if (cmd.commit && action_reg == sst_pkg::ACT_DELETE)
        begin
            count_next = count_reg - sst_pkg::CNT_W'(1);
            for (int i = 0; i < CAP - 1; i++)
            begin
                if (!lt_reg[i])
                    keys_next[i] = keys_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dump_oh_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.dump_start)
                dump_oh_reg <= sst_pkg::row_t'(1);
            else if (cmd.dump_step)
                dump_oh_reg <= dump_oh_reg << 1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAP; i++)
            keys_reg[i] <= keys_next[i];
        if (cmd.load_in)
        begin
            key_reg    <= sst_pkg::key_from_port(key);
            action_reg <= sst_pkg::action_t'(action);
        end
        if (cmd.compare)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        if (cmd.load_prev)
            prev_reg <= sel_key;
        if (cmd.emit_result)
        begin
            status_reg     <= dec;
            value_reg      <= '0;
            has_next_reg   <= 1'b0;
            next_value_reg <= '0;
            has_prev_reg   <= 1'b0;
            prev_value_reg <= '0;
            last_reg       <= 1'b1;
        end
        else if (cmd.emit_query)
        begin
            status_reg     <= sst_pkg::ST_OK;
            value_reg      <= sst_pkg::key_to_port(key_reg);
            has_next_reg   <= |next_oh;
            next_value_reg <= sst_pkg::key_to_port(sel_key);
            has_prev_reg   <= |lt_reg;
            prev_value_reg <= sst_pkg::key_to_port(prev_reg);
            last_reg       <= 1'b1;
        end
        else if (cmd.emit_dump)
        begin
            status_reg     <= sst_pkg::ST_OK;
            value_reg      <= sst_pkg::key_to_port(sel_key);
            has_next_reg   <= 1'b0;
            next_value_reg <= '0;
            has_prev_reg   <= 1'b0;
            prev_value_reg <= '0;
            last_reg       <= stat.dump_last;
        end
    end

    assign status     = status_reg;
    assign value      = value_reg;
    assign has_next   = has_next_reg;
    assign next_value = next_value_reg;
    assign has_prev   = has_prev_reg;
    assign prev_value = prev_value_reg;
    assign last       = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sst_pkg::CNT_W'(CAP))
        else $error("entry count beyond capacity");

    a_eq_unique: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compare |=> $onehot0(eq_reg))
        else $error("key matched more than one entry");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && action_reg == sst_pkg::ACT_INSERT)
        |=> count_reg == $past(count_reg) + sst_pkg::CNT_W'(1))
        else $error("insert did not grow the table by one");

endmodule

// ----- hw/rtl/sorted_set_table.sv -----
// top level of the sorted set table: ascending set of distinct signed keys
//
// input channel (in_valid / in_stall, action, key): one transfer per command.
//   insert adds a key (rejects duplicates and a full table), delete removes
//   one or reports why it is absent, query returns its two neighbors, dump
//   streams every key in ascending order.
// output channel (out_valid / out_stall, status ... last): one transfer per
//   result; a dump gives one per stored key (one with status empty when the
//   table is empty) and marks the final one with last.
// a command is taken in the idle state, then a compare state runs over all
//   cells in parallel, then a decide state, where insert, delete and failed
//   queries end. a hit query adds a neighbor fetch state and an emit state
//   (two passes through the single shared neighbor select); a dump steps
//   through the stored keys while the output register is free. every result
//   is registered.
// the output register holds a result while out_stall is high; the block
//   keeps working up to the point where it needs that register, and a new
//   command may be taken while a result still waits.
// reset empties the table at once (entry count to zero, no clearing pass),
//   drops any held result and returns to idle.
module sorted_set_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [31:0] key,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] value,
    output logic               has_next,
    output logic signed [31:0] next_value,
    output logic               has_prev,
    output logic signed [31:0] prev_value,
    output logic               last
);

    // command and status between sequencer and datapath
    sst_pkg::cmd_t     cmd;
    sst_pkg::dp_stat_t stat;

    // sequencer: idle, compare, decide, neighbor fetch, dump walk
    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // key cells, compare row, shared select and result register
    sst_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (action),
        .key        (key),
        .status     (status),
        .value      (value),
        .has_next   (has_next),
        .next_value (next_value),
        .has_prev   (has_prev),
        .prev_value (prev_value),
        .last       (last)
    );

endmodule

// ----- tb/sorted_set_table_tb.sv -----
// self-checking testbench for the sorted set table, with its own model of the key set
module sorted_set_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // run limit, far above the slowest legal run: every transfer a full dump,
    // every result waiting out the longest stall, every command the longest gap
    localparam int CYCLE_LIMIT   = 400_000;
    // settle time after the last result: a dump of a full table is the slowest command
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_CAP    = 40;

    localparam sst_pkg::port_key_t KEY_MIN = 32'sh8000_0000;
    localparam sst_pkg::port_key_t KEY_MAX = 32'sh7fff_ffff;

    // one expected result, field by field as it leaves the block
    typedef struct packed {
        sst_pkg::status_t   status;
        sst_pkg::port_key_t value;
        logic               has_next;
        sst_pkg::port_key_t next_value;
        logic               has_prev;
        sst_pkg::port_key_t prev_value;
        logic               last;
    } table_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    sst_pkg::action_t   action = sst_pkg::ACT_INSERT;
    sst_pkg::port_key_t key = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    sst_pkg::port_key_t value;
    logic               has_next;
    sst_pkg::port_key_t next_value;
    logic               has_prev;
    sst_pkg::port_key_t prev_value;
    logic               last;

    // predicted contents of the block, kept ascending
    sst_pkg::key_t stored_keys[$];
    // results owed by the block, oldest first
    table_result_t expected_results[$];

    int  cycle_count = 0;
    int  error_count = 0;
    int  commands_sent = 0;
    int  results_checked = 0;
    int  status_tally[7] = '{default: 0};
    int  peak_fill = 0;
    bit  idle_on = 1'b0;
    // receiver hold-off length, counted down by the receiver process itself
    int  hold_off_cycles = 0;

    sorted_set_table uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .value      (value),
        .has_next   (has_next),
        .next_value (next_value),
        .has_prev   (has_prev),
        .prev_value (prev_value),
        .last       (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_results.size());
            $display("sorted_set_table_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void owe_result(sst_pkg::status_t st, sst_pkg::key_t v,
                                       logic hn, sst_pkg::key_t nv,
                                       logic hp, sst_pkg::key_t pv, logic lst);
        table_result_t r;
        r.status     = st;
        r.value      = v;
        r.has_next   = hn;
        r.next_value = nv;
        r.has_prev   = hp;
        r.prev_value = pv;
        r.last       = lst;
        expected_results.push_back(r);
    endfunction

    // a result that carries only a status
    function automatic void owe_status(sst_pkg::status_t st);
        owe_result(st, '0, 1'b0, '0, 1'b0, '0, 1'b1);
    endfunction

    function automatic bit key_stored(sst_pkg::port_key_t k);
        sst_pkg::key_t kk;
        kk = k;
        foreach (stored_keys[i])
            if (stored_keys[i] == kk)
                return 1'b1;
        return 1'b0;
    endfunction

    // apply one accepted command to the predicted set and queue its results
    function automatic void apply_command(sst_pkg::action_t act, sst_pkg::port_key_t k);
        sst_pkg::key_t kk;
        int            n;
        int            pos;
        bit            found;
        kk = k;                     // cut or sign-extend to the stored width
        n  = stored_keys.size();

        if (act == sst_pkg::ACT_DUMP)
        begin
            if (n == 0)
                owe_status(sst_pkg::ST_EMPTY);
            else
                foreach (stored_keys[i])
                    owe_result(sst_pkg::ST_OK, stored_keys[i], 1'b0, '0, 1'b0, '0,
                               i == n - 1);
            return;
        end

        // first entry not below the key
        pos = 0;
        while (pos < n && stored_keys[pos] < kk)
            pos++;
        found = pos < n && stored_keys[pos] == kk;

        if (act == sst_pkg::ACT_INSERT)
        begin
            // a duplicate wins over a full table
            if (found)
                owe_status(sst_pkg::ST_DUP);
            else if (n >= sst_pkg::CAPACITY)
                owe_status(sst_pkg::ST_FULL);
            else
            begin
                stored_keys.insert(pos, kk);
                owe_status(sst_pkg::ST_OK);
                if (stored_keys.size() > peak_fill)
                    peak_fill = stored_keys.size();
            end
        end
        else if (n == 0)
            owe_status(sst_pkg::ST_EMPTY);
        else if (!found)
        begin
            if (pos == 0)
                owe_status(sst_pkg::ST_BELOW);
            else if (pos >= n)
                owe_status(sst_pkg::ST_ABOVE);
            else
                owe_status(sst_pkg::ST_BETWEEN);
        end
        else if (act == sst_pkg::ACT_DELETE)
        begin
            stored_keys.delete(pos);
            owe_status(sst_pkg::ST_OK);
        end
        else
            owe_result(sst_pkg::ST_OK, kk,
                       pos + 1 < n,
                       (pos + 1 < n) ? stored_keys[pos + 1] : sst_pkg::key_t'(0),
                       pos > 0,
                       (pos > 0) ? stored_keys[pos - 1] : sst_pkg::key_t'(0),
                       1'b1);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= REPORT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h (result %0d)",
                                      name, got, want, results_checked));
    endtask

    // every output transfer is matched against the oldest owed result
    always @(posedge clk)
    begin : result_check
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result, status %0d value %h",
                                          status, value));
            else
            begin
                want = expected_results.pop_front();
                check_field("status",     32'(status),     32'(want.status));
                check_field("value",      value,           want.value);
                check_field("has_next",   32'(has_next),   32'(want.has_next));
                check_field("next_value", next_value,      want.next_value);
                check_field("has_prev",   32'(has_prev),   32'(want.has_prev));
                check_field("prev_value", prev_value,      want.prev_value);
                check_field("last",       32'(last),       32'(want.last));
                status_tally[want.status]++;
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts, plus long hold-offs on request
    // ------------------------------------------------------------------

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // one input transfer; valid stays high afterwards until the next
    // falling edge, where the next command or a gap takes over
    task automatic send_command(sst_pkg::action_t act, sst_pkg::port_key_t k);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_command(act, k);
        commands_sent++;
    endtask

    // drop valid and wait until every owed result has come back
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
    endtask

    // keys are mostly hits, near misses and small values so that the
    // searches land on stored entries; a few are extremes or fully random
    function automatic sst_pkg::port_key_t pick_key();
        int n;
        int r;
        n = stored_keys.size();
        r = $urandom_range(0, 9);
        if (r <= 3 && n > 0)
            return stored_keys[$urandom_range(0, n - 1)];
        if (r <= 5 && n > 0)
            return stored_keys[$urandom_range(0, n - 1)] +
                   ($urandom_range(0, 1) ? 1 : -1);
        if (r <= 7)
            return sst_pkg::port_key_t'($urandom_range(0, 64)) - 32;
        if (r == 8)
            case ($urandom_range(0, 5))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_MIN + 1;
                3: return KEY_MAX - 1;
                4: return -1;
                default: return 0;
            endcase
        return sst_pkg::port_key_t'($urandom);
    endfunction

    // inserts back off once the table is mostly full so deletes keep up
    function automatic sst_pkg::action_t pick_action();
        int r;
        int ins;
        ins = (stored_keys.size() < 24) ? 40 : 25;
        r = $urandom_range(0, 99);
        if (r < ins)
            return sst_pkg::ACT_INSERT;
        if (r < ins + 28)
            return sst_pkg::ACT_DELETE;
        if (r < ins + 58)
            return sst_pkg::ACT_QUERY;
        return sst_pkg::ACT_DUMP;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every command on an empty table, then a table of one entry
    task automatic test_empty_table();
        send_command(sst_pkg::ACT_QUERY, 0);
        send_command(sst_pkg::ACT_DELETE, KEY_MIN);
        send_command(sst_pkg::ACT_DUMP, KEY_MAX);
        send_command(sst_pkg::ACT_INSERT, 7);
        send_command(sst_pkg::ACT_QUERY, 7);       // no neighbor on either side
        send_command(sst_pkg::ACT_DELETE, 7);
    endtask

    // misses of each kind, neighbor edges and the extreme keys
    task automatic test_directed_edges();
        send_command(sst_pkg::ACT_INSERT, 5);
        send_command(sst_pkg::ACT_INSERT, -5);
        send_command(sst_pkg::ACT_INSERT, 5);      // duplicate
        send_command(sst_pkg::ACT_DELETE, -100);   // below smallest
        send_command(sst_pkg::ACT_QUERY, 100);     // above largest
        send_command(sst_pkg::ACT_QUERY, 0);       // between entries
        // a new smallest key must not make the next insert look like a duplicate
        send_command(sst_pkg::ACT_INSERT, -10);
        send_command(sst_pkg::ACT_INSERT, 0);      // middle insert, later entries shift up
        send_command(sst_pkg::ACT_QUERY, 0);
        send_command(sst_pkg::ACT_QUERY, -10);
        send_command(sst_pkg::ACT_QUERY, 5);
        send_command(sst_pkg::ACT_INSERT, KEY_MIN);
        send_command(sst_pkg::ACT_INSERT, KEY_MAX);
        send_command(sst_pkg::ACT_QUERY, KEY_MIN);
        send_command(sst_pkg::ACT_QUERY, KEY_MAX);
        send_command(sst_pkg::ACT_DELETE, 0);      // middle delete
        send_command(sst_pkg::ACT_DELETE, KEY_MIN);
        send_command(sst_pkg::ACT_DELETE, KEY_MAX);
        send_command(sst_pkg::ACT_DELETE, 100);
        send_command(sst_pkg::ACT_DUMP, 0);
    endtask

    // fill with random keys, then the full-table rules and a full dump
    task automatic test_full_table();
        sst_pkg::port_key_t k;
        while (stored_keys.size() < sst_pkg::CAPACITY)
            send_command(sst_pkg::ACT_INSERT, sst_pkg::port_key_t'($urandom));
        do
            k = sst_pkg::port_key_t'($urandom);
        while (key_stored(k));
        send_command(sst_pkg::ACT_INSERT, k);                          // full
        // duplicate beats full
        send_command(sst_pkg::ACT_INSERT, stored_keys[sst_pkg::CAPACITY / 2]);
        send_command(sst_pkg::ACT_QUERY, stored_keys[sst_pkg::CAPACITY - 1]);
        send_command(sst_pkg::ACT_DUMP, k);                            // longest dump
        send_command(sst_pkg::ACT_DELETE, stored_keys[0]);
        send_command(sst_pkg::ACT_INSERT, k);
        send_command(sst_pkg::ACT_INSERT, ~k);
    endtask

    // receiver holds off while the sender keeps offering, so the block
    // backs up into its input; then the sender waits for the drain
    task automatic test_output_hold_off();
        int i;
        idle_on = 1'b0;
        hold_off_cycles = 150;
        send_command(sst_pkg::ACT_DUMP, 0);
        for (i = 0; i < 12; i++)
            send_command(pick_action(), pick_key());
        wait_drain();
    endtask

    // bulk random traffic with idling on both sides and a full drain midway
    task automatic test_random_mix(int n_items);
        int i;
        idle_on = 1'b1;
        for (i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                wait_drain();
            send_command(pick_action(), pick_key());
        end
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_streaming(int n_items);
        int i;
        idle_on = 1'b0;
        for (i = 0; i < n_items; i++)
            send_command(pick_action(), pick_key());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_directed_edges();
        idle_on = 1'b1;
        test_full_table();
        test_output_hold_off();
        test_random_mix(70);
        test_streaming(35);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d commands, %0d results, peak fill %0d of %0d, %0d cycles",
                 commands_sent, results_checked, peak_fill, sst_pkg::CAPACITY,
                 cycle_count);
        $display("results by status: ok %0d dup %0d empty %0d below %0d",
                 status_tally[sst_pkg::ST_OK], status_tally[sst_pkg::ST_DUP],
                 status_tally[sst_pkg::ST_EMPTY], status_tally[sst_pkg::ST_BELOW]);
        $display("  above %0d between %0d full %0d",
                 status_tally[sst_pkg::ST_ABOVE], status_tally[sst_pkg::ST_BETWEEN],
                 status_tally[sst_pkg::ST_FULL]);
        if (error_count == 0)
            $display("sorted_set_table_tb: clean");
        else
            $display("sorted_set_table_tb: errors");
        $finish;
    end

endmodule
